### rtl/mactp_pkg.sv
// Package for the text Ethernet address parser.
// Beat types, parser phase encoding, character constants and hex decode.
// No dependencies.
package mactp_pkg;

  localparam int unsigned NumOctets = 6;
  localparam int unsigned AddrWidth = 8 * NumOctets;
  localparam logic [2:0]  LastComp  = 3'(NumOctets - 1);
  localparam logic [2:0]  AllStored = 3'(NumOctets);

  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [3:0] HexTen    = 4'd10;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhFirst = 2'd1,
    PhOne   = 2'd2,
    PhTwo   = 2'd3
  } phase_e;

  typedef struct packed {
    logic       start_req;
    logic [7:0] char_in;
  } in_beat_t;

  typedef struct packed {
    logic                 accepted;
    logic [AddrWidth-1:0] address;
    logic [2:0]           octets_stored;
  } out_beat_t;

  typedef struct packed {
    logic      emit;
    out_beat_t beat;
  } core_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t       h;
    logic [7:0] diff;
    h    = '{ok: 1'b0, val: 4'd0};
    diff = 8'd0;
    if (c inside {[CharZero:CharNine]}) begin
      diff = c - CharZero;
      h    = '{ok: 1'b1, val: diff[3:0]};
    end else if (c inside {[CharLowA:CharLowF]}) begin
      diff = c - CharLowA;
      h    = '{ok: 1'b1, val: diff[3:0] + HexTen};
    end else if (c inside {[CharUpA:CharUpF]}) begin
      diff = c - CharUpA;
      h    = '{ok: 1'b1, val: diff[3:0] + HexTen};
    end
    return h;
  endfunction

endpackage

### rtl/mac_address_text_parser_unit.sv
// Top level of the text Ethernet address parser: input register, step, result register.
// Uses mactp_pkg and mactp_core.
//
//  channel  dir  handshake               payload
//  in       in   in_valid_i/in_stall_o   mactp_pkg::in_beat_t  in_beat_i
//  out      out  out_valid_o/out_stall_i mactp_pkg::out_beat_t out_beat_o
//
// One character beat per cycle sustained while the output is not stalled; the deciding
// beat passes through the input register and the step logic into the result register.
// Reset returns the parser to idle with a cleared address store.
// in_stall_o rises while the input register is full and a held result is
// stalled at the output.
module mac_address_text_parser_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  mactp_pkg::in_beat_t   in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mactp_pkg::out_beat_t  out_beat_o
);

  logic                  in_valid_q;
  mactp_pkg::in_beat_t   in_q;
  logic                  out_valid_q;
  mactp_pkg::out_beat_t  out_q;
  logic                  out_free;
  logic                  step;
  mactp_pkg::core_res_t  res;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  mactp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .beat_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.emit) begin
      out_q <= res.beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  a_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_beat_o.accepted |-> out_beat_o.octets_stored == mactp_pkg::AllStored)
    else $error("accepted result without all octets stored");

  a_refuse_part: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_beat_o.accepted |-> out_beat_o.octets_stored <= mactp_pkg::LastComp)
    else $error("refused result counts too many octets");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled with room to proceed");

  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.emit |=> out_valid_q)
    else $error("result lost on its way to the output register");

endmodule

### rtl/mactp_core.sv
// Parser state and one-character step logic for the address parser.
// Uses mactp_pkg; stepped by the top level once per registered input beat.
module mactp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  mactp_pkg::in_beat_t  beat_i,
  output mactp_pkg::core_res_t res_o
);

  mactp_pkg::phase_e                  phase_q, phase_d;
  logic [2:0]                         comp_q, comp_d;
  logic [7:0]                         part_q, part_d;
  logic [mactp_pkg::AddrWidth-1:0]    addr_q, addr_d;

  mactp_pkg::phase_e                  phase_v;
  logic [2:0]                         comp_v;
  logic [7:0]                         part_v;
  logic [2:0]                         idx;
  logic [2:0]                         byte_sel;
  logic [mactp_pkg::AddrWidth-1:0]    addr_wr;
  mactp_pkg::hex_t                    hx;

  assign hx       = mactp_pkg::hex_decode(beat_i.char_in);
  assign phase_v  = beat_i.start_req ? mactp_pkg::PhFirst : phase_q;
  assign comp_v   = beat_i.start_req ? 3'd0 : comp_q;
  assign part_v   = beat_i.start_req ? 8'd0 : part_q;
  assign idx      = (comp_v > mactp_pkg::LastComp) ? mactp_pkg::LastComp : comp_v;
  assign byte_sel = mactp_pkg::LastComp - idx;

  always_comb begin
    addr_wr = addr_q;
    for (int k = 0; k < mactp_pkg::NumOctets; k++) begin
      if (byte_sel == 3'(k)) begin
        addr_wr[8*k +: 8] = part_v;
      end
    end
  end

  always_comb begin
    phase_d    = phase_v;
    comp_d     = comp_v;
    part_d     = part_v;
    addr_d     = addr_q;
    res_o.emit = 1'b0;
    res_o.beat.accepted      = 1'b0;
    res_o.beat.octets_stored = comp_v;
    case (phase_v)
      mactp_pkg::PhFirst: begin
        if (!hx.ok) begin
          res_o.emit = 1'b1;
          phase_d    = mactp_pkg::PhIdle;
        end else begin
          part_d  = {4'd0, hx.val};
          phase_d = mactp_pkg::PhOne;
        end
      end
      mactp_pkg::PhOne, mactp_pkg::PhTwo: begin
        if (hx.ok) begin
          if (phase_v == mactp_pkg::PhOne) begin
            part_d  = {part_v[3:0], hx.val};
            phase_d = mactp_pkg::PhTwo;
          end else begin
            res_o.emit = 1'b1;
            phase_d    = mactp_pkg::PhIdle;
          end
        end else if (idx < mactp_pkg::LastComp && beat_i.char_in != mactp_pkg::CharColon) begin
          res_o.emit               = 1'b1;
          res_o.beat.octets_stored = idx;
          phase_d                  = mactp_pkg::PhIdle;
        end else begin
          addr_d = addr_wr;
          if (idx >= mactp_pkg::LastComp) begin
            res_o.emit               = 1'b1;
            res_o.beat.accepted      = 1'b1;
            res_o.beat.octets_stored = mactp_pkg::AllStored;
            phase_d                  = mactp_pkg::PhIdle;
          end else begin
            comp_d  = idx + 3'd1;
            part_d  = 8'd0;
            phase_d = mactp_pkg::PhFirst;
          end
        end
      end
      default: begin
        phase_d = mactp_pkg::PhIdle;
      end
    endcase
    res_o.beat.address = addr_d;
    if (!step_i) begin
      res_o.emit = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mactp_pkg::PhIdle;
      comp_q  <= 3'd0;
      part_q  <= 8'd0;
      addr_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      comp_q  <= comp_d;
      part_q  <= part_d;
      addr_q  <= addr_d;
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for mac_address_text_parser_unit: streams address text beats and checks
// each decision against a built-in parser model. Uses mactp_pkg and the unit's RTL.
module tb_top;
  import mactp_pkg::*;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharHigh  = 8'hff;
  localparam logic [7:0] CharLowX  = 8'h78;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat  = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  mac_address_text_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  in_beat_t  char_q[$];
  out_beat_t decision_q[$];

  phase_e               pr_phase = PhIdle;
  logic [2:0]           pr_comp  = '0;
  logic [7:0]           pr_part  = '0;
  logic [AddrWidth-1:0] pr_addr  = '0;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int          n_bad     = 0;
  int          n_chars   = 0;

  function automatic bit hex_of(input logic [7:0] c, output logic [3:0] v);
    logic [7:0] d;
    bit         ok;
    d  = 8'd0;
    ok = 1'b1;
    if (c >= CharZero && c <= CharNine) begin
      d = c - CharZero;
    end else if (c >= CharLowA && c <= CharLowF) begin
      d = c - CharLowA + 8'(HexTen);
    end else if (c >= CharUpA && c <= CharUpF) begin
      d = c - CharUpA + 8'(HexTen);
    end else begin
      ok = 1'b0;
    end
    v = d[3:0];
    return ok;
  endfunction

  // One character into the parser model; returns 1 when it decides the string.
  function automatic bit parse_char(input in_beat_t b, output out_beat_t r);
    logic [3:0] v;
    logic [2:0] cnt;
    bit         is_hex;
    bit         closing;
    bit         done;
    bit         ok;
    is_hex  = hex_of(b.char_in, v);
    closing = 1'b0;
    done    = 1'b0;
    ok      = 1'b0;
    r       = '0;
    if (b.start_req) begin
      pr_phase = PhFirst;
      pr_comp  = '0;
      pr_part  = '0;
    end
    case (pr_phase)
      PhFirst: begin
        if (is_hex) begin
          pr_part  = {4'd0, v};
          pr_phase = PhOne;
        end else begin
          done = 1'b1;
        end
      end
      PhOne: begin
        if (is_hex) begin
          pr_part  = {pr_part[3:0], v};
          pr_phase = PhTwo;
        end else begin
          closing = 1'b1;
        end
      end
      PhTwo: begin
        if (is_hex) done = 1'b1;
        else closing = 1'b1;
      end
      default: ;
    endcase
    cnt = pr_comp;
    if (closing) begin
      if (pr_comp != LastComp && b.char_in != CharColon) begin
        done = 1'b1;
      end else begin
        pr_addr[8*(int'(LastComp) - int'(pr_comp)) +: 8] = pr_part;
        if (pr_comp == LastComp) begin
          done = 1'b1;
          ok   = 1'b1;
          cnt  = AllStored;
        end else begin
          pr_comp  = pr_comp + 3'd1;
          pr_part  = '0;
          pr_phase = PhFirst;
        end
      end
    end
    if (done) begin
      pr_phase = PhIdle;
      r = '{accepted: ok, address: pr_addr, octets_stored: cnt};
    end
    return done;
  endfunction

  function automatic logic [7:0] rand_hex();
    int unsigned k;
    k = $urandom_range(21);
    if (k < 10) return CharZero + 8'(k);
    if (k < 16) return CharLowA + 8'(k - 10);
    return CharUpA + 8'(k - 16);
  endfunction

  task automatic add_char(input bit s, input logic [7:0] c);
    char_q.push_back('{start_req: s, char_in: c});
    n_chars++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(i == 0, s[i]);
  endtask

  // Mostly well-formed addresses; the rest are damaged, cut short or abandoned.
  task automatic add_address();
    logic [7:0]  txt[$];
    int unsigned kind;
    int unsigned cut;
    kind = $urandom_range(99);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 4)) add_char(1'b0, 8'($urandom_range(255)));
    end
    for (int comp = 0; comp < NumOctets; comp++) begin
      repeat ($urandom_range(1, 2)) txt.push_back(rand_hex());
      if (comp < NumOctets - 1) txt.push_back(CharColon);
    end
    if ($urandom_range(3) == 0) begin
      txt.push_back($urandom_range(1) ? CharColon : CharSpace);
      repeat ($urandom_range(3)) txt.push_back(8'($urandom_range(1, 255)));
    end
    txt.push_back(CharNul);
    if (kind >= 60 && kind < 72) begin
      txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
    end else if (kind >= 72 && kind < 82) begin
      txt.insert($urandom_range(txt.size() - 1), rand_hex());
    end else if (kind >= 82) begin
      cut = $urandom_range(1, txt.size() - 1);
      while (txt.size() > cut) void'(txt.pop_back());
      if (kind >= 91) txt.push_back(CharNul);
    end
    foreach (txt[i]) add_char(i == 0, txt[i]);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin : drive
    out_beat_t r;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (parse_char(in_beat, r)) decision_q.push_back(r);
      end
      if (!in_valid || !in_stall) begin
        if (char_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_beat  <= char_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_beat_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decision_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected beat: acc=%0d addr=%h n=%0d",
                     out_beat.accepted, out_beat.address, out_beat.octets_stored);
        end else begin
          want = decision_q.pop_front();
          if (out_beat.accepted !== want.accepted || out_beat.address !== want.address ||
              out_beat.octets_stored !== want.octets_stored) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch: exp acc=%0d addr=%h n=%0d, got acc=%0d addr=%h n=%0d",
                       want.accepted, want.address, want.octets_stored,
                       out_beat.accepted, out_beat.address, out_beat.octets_stored);
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : run
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    idle_tab  = '{0, 80, 0, 17};
    stall_tab = '{0, 0, 80, 17};
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  <= idle_tab[ph];
      stall_pct <= stall_tab[ph];
      if (ph == 0) begin
        add_text("00:FF:aB:9f:0A:Ff");
        add_char(1'b0, CharNul);
        add_char(1'b0, CharHigh);
        add_char(1'b0, CharLowX);
        add_char(1'b1, CharNul);
        add_text("123");
        add_text("7-");
      end
      while (n_chars < 240 * (ph + 1)) add_address();
      while (char_q.size() != 0 || in_valid) @(posedge clk_i);
      while (decision_q.size() != 0) @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (n_bad == 0 && decision_q.size() == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
